// ===== rtl/gpad_pkg.sv =====
// Shared constants, types and helper functions for the gamepad edge and auto-repeat block.
package gpad_pkg;

    localparam int NumRaw     = 20;
    localparam int NumOut     = 22;
    localparam int NumButtons = 12;
    localparam int CntW       = 4;

    localparam logic [CntW-1:0] RepeatStart = 4'd10;
    localparam logic [CntW-1:0] SlowReload  = 4'd6;
    localparam logic [CntW-1:0] CntMax      = 4'd11;

    localparam int LineCircle = 7;
    localparam int LineCross  = 8;
    localparam int BitEnter   = 12;
    localparam int BitCancel  = 13;

    localparam logic [7:0] LowLimitReset  = 8'd64;
    localparam logic [7:0] HighLimitReset = 8'd192;

    typedef enum logic [1:0] {
        CFG_ENTER_IS_CIRCLE = 2'd0,
        CFG_LOW_LIMIT       = 2'd1,
        CFG_HIGH_LIMIT      = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [NumOut-1:0] level;
        logic [NumOut-1:0] pressed;
        logic [NumOut-1:0] released;
        logic [NumOut-1:0] slow;
        logic [NumOut-1:0] fast;
    } result_t;

    // Moves a raw line mask into output order and fills in the enter and cancel bits.
    function automatic logic [NumOut-1:0] to_out(input logic [NumRaw-1:0] raw,
                                                  input logic enter_is_circle);
        logic [NumOut-1:0] m;
        m = {raw[NumRaw-1:NumButtons], 2'b00, raw[NumButtons-1:0]};
        m[BitEnter]  = enter_is_circle ? raw[LineCircle] : raw[LineCross];
        m[BitCancel] = enter_is_circle ? raw[LineCross] : raw[LineCircle];
        return m;
    endfunction

    // Two direction bits from one axis; the low compare wins when the limits cross.
    function automatic logic [1:0] axis_dirs(input logic [7:0] a,
                                             input logic [7:0] lo,
                                             input logic [7:0] hi);
        logic [1:0] d;
        d = 2'b00;
        if (a < lo) begin
            d = 2'b01;
        end else if (a > hi) begin
            d = 2'b10;
        end
        return d;
    endfunction

endpackage

// ===== rtl/gpad_core.sv =====
// Configuration registers, per-line hold counters and the edge and repeat logic.
module gpad_core
    import gpad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        accept,
    input  logic [11:0] button_bits,
    input  logic [7:0]  left_x,
    input  logic [7:0]  left_y,
    input  logic [7:0]  right_x,
    input  logic [7:0]  right_y,
    output result_t     result
);

    logic            enter_is_circle_reg;
    logic [7:0]      low_limit_reg;
    logic [7:0]      high_limit_reg;
    logic [NumRaw-1:0] prev_reg;
    logic [CntW-1:0] slow_cnt_reg  [NumRaw];
    logic [CntW-1:0] fast_cnt_reg  [NumRaw];
    logic [CntW-1:0] slow_cnt_next [NumRaw];
    logic [CntW-1:0] fast_cnt_next [NumRaw];

    logic [NumRaw-1:0] cur;
    logic [NumRaw-1:0] pressed;
    logic [NumRaw-1:0] released;
    logic [NumRaw-1:0] slow_pulse;
    logic [NumRaw-1:0] fast_pulse;
    logic [NumRaw-1:0] cnt_bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            enter_is_circle_reg <= 1'b0;
            low_limit_reg       <= LowLimitReset;
            high_limit_reg      <= HighLimitReset;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ENTER_IS_CIRCLE: enter_is_circle_reg <= cfg_wdata[0];
                CFG_LOW_LIMIT:       low_limit_reg       <= cfg_wdata;
                CFG_HIGH_LIMIT:      high_limit_reg      <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        cur = {axis_dirs(right_x, low_limit_reg, high_limit_reg),
               axis_dirs(right_y, low_limit_reg, high_limit_reg),
               axis_dirs(left_x, low_limit_reg, high_limit_reg),
               axis_dirs(left_y, low_limit_reg, high_limit_reg),
               button_bits};
        pressed  = cur & ~prev_reg;
        released = ~cur & prev_reg;
    end

    for (genvar i = 0; i < NumRaw; i++) begin : g_line
        logic [CntW-1:0] s;
        logic [CntW-1:0] f;

        always_comb
        begin
            s = slow_cnt_reg[i];
            f = fast_cnt_reg[i];
            slow_pulse[i] = 1'b0;
            fast_pulse[i] = 1'b0;
            if (s >= RepeatStart) begin
                slow_pulse[i] = cur[i];
                s = SlowReload;
            end
            if (f >= RepeatStart) begin
                fast_pulse[i] = cur[i];
                f = RepeatStart;
            end
            slow_cnt_next[i] = cur[i] ? s + 1'b1 : '0;
            fast_cnt_next[i] = cur[i] ? f + 1'b1 : '0;
            cnt_bad[i] = (slow_cnt_reg[i] > CntMax) || (fast_cnt_reg[i] > CntMax);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                slow_cnt_reg[i] <= '0;
                fast_cnt_reg[i] <= '0;
            end else if (accept) begin
                slow_cnt_reg[i] <= slow_cnt_next[i];
                fast_cnt_reg[i] <= fast_cnt_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prev_reg <= '0;
        end else if (accept) begin
            prev_reg <= cur;
        end
    end

    always_comb
    begin
        result.level    = to_out(cur, enter_is_circle_reg);
        result.pressed  = to_out(pressed, enter_is_circle_reg);
        result.released = to_out(released, enter_is_circle_reg);
        result.slow     = to_out(pressed | slow_pulse, enter_is_circle_reg);
        result.fast     = to_out(pressed | fast_pulse, enter_is_circle_reg);
    end

    // Counters started from reset never go beyond eleven.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_bad == '0)
        else $error("hold counter out of range");

    // The stored levels follow the line levels of the last accepted sample.
    a_prev_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> prev_reg == $past(cur))
        else $error("previous levels not updated");

    // A line cannot be pressed and released in the same sample.
    a_edge_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (pressed & released) == '0)
        else $error("press and release edges overlap");

    // Line 0 has its counters cleared after an accepted sample in which it is not held.
    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cur[0] |=> slow_cnt_reg[0] == '0 && fast_cnt_reg[0] == '0)
        else $error("counter not cleared on release");

endmodule

// ===== rtl/gpad_skid.sv =====
// Output register with a skid entry so that input transactions continue while a result waits.
module gpad_skid
    import gpad_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    accept;
    logic    out_free;

    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free) begin
            skid_valid_next = 1'b0;
            if (skid_valid_reg) begin
                out_valid_next = 1'b1;
                out_data_next  = skid_data_reg;
            end else begin
                out_valid_next = accept;
                out_data_next  = in_data;
            end
        end else if (accept) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // The skid entry is only ever filled behind a held output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output");

    // A transaction taken while the output is held lands in the skid entry.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        accept && out_valid_reg && out_stall |=> skid_valid_reg && skid_data_reg == $past(in_data))
        else $error("held result lost a transaction");

    // A drained skid entry moves to the output.
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !out_stall |=> out_valid_reg && out_data_reg == $past(skid_data_reg))
        else $error("skid entry not forwarded");

endmodule

// ===== rtl/gamepad_edge_and_autorepeat.sv =====
// Top level of the gamepad edge detector with slow and fast auto-repeat.
// An accepted sample's result is registered at the output, or in the skid entry when held.
// Throughput: one sample per cycle while in_stall is low; a two-entry output buffer keeps
// input open while one result waits, and in_stall rises only when both entries are full.
// Reset clears levels, hold counters and output valids, and sets the limits to 64 and 192.
module gamepad_edge_and_autorepeat
    import gpad_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [11:0]        button_bits,
    input  logic [7:0]         left_x,
    input  logic [7:0]         left_y,
    input  logic [7:0]         right_x,
    input  logic [7:0]         right_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [NumOut-1:0]  level_mask,
    output logic [NumOut-1:0]  pressed_mask,
    output logic [NumOut-1:0]  released_mask,
    output logic [NumOut-1:0]  slow_repeat_mask,
    output logic [NumOut-1:0]  fast_repeat_mask
);

    result_t result;
    result_t out_data;
    logic    accept;

    assign accept = in_valid && !in_stall;

    gpad_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .accept      (accept),
        .button_bits (button_bits),
        .left_x      (left_x),
        .left_y      (left_y),
        .right_x     (right_x),
        .right_y     (right_y),
        .result      (result)
    );

    gpad_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (result),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign level_mask       = out_data.level;
    assign pressed_mask     = out_data.pressed;
    assign released_mask    = out_data.released;
    assign slow_repeat_mask = out_data.slow;
    assign fast_repeat_mask = out_data.fast;

endmodule
